// ----- rtl/pcrt_pkg.sv -----
package pcrt_pkg;

    localparam int RANGES      = 16;
    localparam int FRAC_BITS   = 16;
    localparam int TIME_FRAC   = 16;
    localparam int IDX_W       = 4;
    localparam int CNT_W       = 5;
    localparam int PHASE_INT_W = 14;
    localparam int ACC_W       = PHASE_INT_W + FRAC_BITS;
    localparam int MAG_W       = 16;
    localparam int ELAPSED_W   = 16;
    localparam int PROD_W      = MAG_W + ELAPSED_W;
    localparam int SCALE_W     = PROD_W + 6;
    localparam int INC_SHL     = (FRAC_BITS >= TIME_FRAC) ? FRAC_BITS - TIME_FRAC : 0;
    localparam int INC_SHR     = (FRAC_BITS < TIME_FRAC) ? TIME_FRAC - FRAC_BITS : 0;
    localparam int INC_W       = SCALE_W + INC_SHL;
    localparam int SUM_W       = ((INC_W > ACC_W) ? INC_W : ACC_W) + 1;

    typedef enum logic {
        FUNC_LOAD = 1'b0,
        FUNC_TICK = 1'b1
    } t_func;

    typedef struct packed {
        t_func              func;
        logic [3:0]         channel;
        logic [7:0]         low_index;
        logic [7:0]         high_index;
        logic signed [15:0] rate;
        logic [15:0]        elapsed;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  range_index;
        logic [7:0]  position;
        logic        stepped;
        logic [13:0] phase;
        logic        last;
    } t_out_item;

endpackage

// ----- rtl/pcrt_advance.sv -----
module pcrt_advance (
    input  logic [pcrt_pkg::PROD_W-1:0] i_prod,
    input  logic [pcrt_pkg::ACC_W-1:0]  i_acc,
    input  logic [7:0]                  i_pos,
    input  logic [7:0]                  i_low,
    input  logic [7:0]                  i_high,
    input  logic                        i_neg,
    output logic [pcrt_pkg::ACC_W-1:0]  o_acc,
    output logic [7:0]                  o_pos,
    output logic                        o_stepped
);

    logic [pcrt_pkg::INC_W-1:0] w_scaled;
    logic [pcrt_pkg::INC_W-1:0] w_inc;
    logic [pcrt_pkg::SUM_W-1:0] w_sum;
    logic                       w_wrap;
    logic [7:0]                 w_len8;
    logic [8:0]                 w_len;
    logic [8:0]                 w_up;
    logic [8:0]                 w_len_m1;
    logic [7:0]                 w_step_pos;

    // x * 60 = x * 64 - x * 4
    assign w_scaled = (pcrt_pkg::INC_W'(i_prod) << 6) - (pcrt_pkg::INC_W'(i_prod) << 2);
    assign w_inc    = (w_scaled << pcrt_pkg::INC_SHL) >> pcrt_pkg::INC_SHR;
    assign w_sum    = pcrt_pkg::SUM_W'(i_acc) + pcrt_pkg::SUM_W'(w_inc);
    assign w_wrap   = |w_sum[pcrt_pkg::SUM_W-1:pcrt_pkg::ACC_W];

    assign w_len8   = i_high + 8'd1 - i_low;
    assign w_len    = {(w_len8 == 8'd0), w_len8};
    assign w_up     = {1'b0, i_pos} + 9'd1;
    assign w_len_m1 = w_len - 9'd1;

    always_comb begin
        if (i_neg) begin
            w_step_pos = (w_up == w_len) ? 8'd0 : w_up[7:0];
        end else begin
            w_step_pos = (i_pos == 8'd0) ? w_len_m1[7:0] : i_pos - 8'd1;
        end
    end

    assign o_acc     = w_sum[pcrt_pkg::ACC_W-1:0];
    assign o_pos     = w_wrap ? w_step_pos : i_pos;
    assign o_stepped = w_wrap;

endmodule

// ----- rtl/palette_cycle_range_timers_core.sv -----
// Load transfer: produces no result; the next item can be accepted in the cycle after.
// Tick transfer: each active range passes through the multiply, accumulate and output
// states in turn, holding in output while the output is stalled; no new item is accepted
// until the last range's result is taken. A tick with no active ranges gives no result.
// One shared 16x16 multiplier and one accumulate/step unit serve all ranges in turn.
// Synchronous active-low reset clears all range tables, phases, positions and the
// active range count; the block is ready in the first cycle after reset.
module palette_cycle_range_timers_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  pcrt_pkg::t_in_item         i_in,
    output logic                       o_valid,
    input  logic                       i_stall,
    output pcrt_pkg::t_out_item        o_out,
    input  logic                       i_cfg_we,
    input  logic [pcrt_pkg::CNT_W-1:0] i_cfg_wdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_OUT
    } t_state;

    t_state                        r_state, n_state;
    logic [pcrt_pkg::CNT_W-1:0]    r_active;
    logic [pcrt_pkg::IDX_W-1:0]    r_idx, n_idx;
    logic [pcrt_pkg::IDX_W-1:0]    r_last_idx, n_last_idx;
    logic [pcrt_pkg::ELAPSED_W-1:0] r_elapsed;
    logic [pcrt_pkg::PROD_W-1:0]   r_prod;
    logic                          r_valid, n_valid;
    pcrt_pkg::t_out_item           r_out;

    logic [7:0]                    r_low   [pcrt_pkg::RANGES];
    logic [7:0]                    r_high  [pcrt_pkg::RANGES];
    logic [15:0]                   r_rate  [pcrt_pkg::RANGES];
    logic [pcrt_pkg::ACC_W-1:0]    r_acc   [pcrt_pkg::RANGES];
    logic [7:0]                    r_pos   [pcrt_pkg::RANGES];

    logic                          w_in_xfer;
    logic                          w_out_xfer;
    logic [pcrt_pkg::CNT_W-1:0]    w_count;
    logic [15:0]                   w_rate;
    logic [pcrt_pkg::MAG_W-1:0]    w_mag;
    logic [pcrt_pkg::ACC_W-1:0]    w_new_acc;
    logic [7:0]                    w_new_pos;
    logic                          w_stepped;

    assign o_stall    = (r_state != S_IDLE);
    assign w_in_xfer  = i_valid && !o_stall;
    assign w_out_xfer = r_valid && !i_stall;
    assign o_valid    = r_valid;
    assign o_out      = r_out;

    assign w_count = (r_active > pcrt_pkg::CNT_W'(pcrt_pkg::RANGES))
                   ? pcrt_pkg::CNT_W'(pcrt_pkg::RANGES) : r_active;
    assign w_rate  = r_rate[r_idx];
    assign w_mag   = w_rate[15] ? pcrt_pkg::MAG_W'(16'd0 - w_rate) : w_rate;

    pcrt_advance u_advance (
        .i_prod    (r_prod),
        .i_acc     (r_acc[r_idx]),
        .i_pos     (r_pos[r_idx]),
        .i_low     (r_low[r_idx]),
        .i_high    (r_high[r_idx]),
        .i_neg     (w_rate[15]),
        .o_acc     (w_new_acc),
        .o_pos     (w_new_pos),
        .o_stepped (w_stepped)
    );

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_last_idx = r_last_idx;
        n_valid    = r_valid;
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer && i_in.func == pcrt_pkg::FUNC_TICK && w_count != '0) begin
                    n_state    = S_MUL;
                    n_idx      = '0;
                    n_last_idx = pcrt_pkg::IDX_W'(w_count - pcrt_pkg::CNT_W'(1));
                end
            end
            S_MUL: begin
                n_state = S_ACC;
            end
            S_ACC: begin
                n_state = S_OUT;
                n_valid = 1'b1;
            end
            S_OUT: begin
                if (w_out_xfer) begin
                    n_valid = 1'b0;
                    if (r_idx == r_last_idx) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_MUL;
                        n_idx   = r_idx + pcrt_pkg::IDX_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
                n_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_active   <= '0;
            r_idx      <= '0;
            r_last_idx <= '0;
            r_valid    <= 1'b0;
            for (int k = 0; k < pcrt_pkg::RANGES; k++) begin
                r_low[k]  <= '0;
                r_high[k] <= '0;
                r_rate[k] <= '0;
                r_acc[k]  <= '0;
                r_pos[k]  <= '0;
            end
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_last_idx <= n_last_idx;
            r_valid    <= n_valid;
            if (i_cfg_we) begin
                r_active <= i_cfg_wdata;
            end
            if (w_in_xfer && i_in.func == pcrt_pkg::FUNC_LOAD) begin
                r_low[i_in.channel]  <= i_in.low_index;
                r_high[i_in.channel] <= i_in.high_index;
                r_rate[i_in.channel] <= i_in.rate;
                r_acc[i_in.channel]  <= '0;
                r_pos[i_in.channel]  <= '0;
            end
            if (r_state == S_ACC) begin
                r_acc[r_idx] <= w_new_acc;
                r_pos[r_idx] <= w_new_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_elapsed <= i_in.elapsed;
        end
        if (r_state == S_MUL) begin
            r_prod <= pcrt_pkg::PROD_W'(w_mag) * pcrt_pkg::PROD_W'(r_elapsed);
        end
        if (r_state == S_ACC) begin
            r_out.range_index <= r_idx;
            r_out.position    <= w_new_pos;
            r_out.stepped     <= w_stepped;
            r_out.phase       <= w_new_acc[pcrt_pkg::ACC_W-1:pcrt_pkg::FRAC_BITS];
            r_out.last        <= (r_idx == r_last_idx);
        end
    end

    a_valid_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid == (r_state == S_OUT))
        else $error("result valid outside output state");

    a_last_ends_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_out.last) |=> (r_state == S_IDLE))
        else $error("tick did not end after last result");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_idx <= r_last_idx))
        else $error("range walk passed the last active range");

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && i_in.func == pcrt_pkg::FUNC_LOAD) |=> (r_state == S_IDLE && !o_valid))
        else $error("load transfer started a walk");

endmodule
